[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RMAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rmau_pkg.sv]
package rmau_pkg;

    localparam int FIELD_W      = 60;
    localparam int FUNC_W       = 3;
    localparam int ROW_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int EXP_W        = 16;
    localparam int ROW_REGS     = 4;
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 6;
    localparam int NUM_PRIMES_D = 4;
    localparam int RES_BITS_D   = 60;

    localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DIV = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POW = 3'd4;

    localparam logic [2:0] REG_PRIME0 = 3'd0;
    localparam logic [2:0] REG_PRIME1 = 3'd1;
    localparam logic [2:0] REG_PRIME2 = 3'd2;
    localparam logic [2:0] REG_PRIME3 = 3'd3;
    localparam logic [2:0] REG_EXP    = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOINV  = 2'd2,
        ST_BADROW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_EUC_CHK,
        S_EUC_DIV,
        S_EUC_UPD,
        S_POW,
        S_DONE
    } t_state;

    // where a finished multiply goes
    typedef enum logic [1:0] {
        MD_FINAL,
        MD_ACC,
        MD_BASE
    } t_mul_dst;

endpackage

[rtl/core/rmau_in_if.sv]
interface rmau_in_if;
    logic                           valid;
    logic                           ready;
    logic [rmau_pkg::FUNC_W-1:0]    func;
    logic [rmau_pkg::ROW_W-1:0]     row_sel;
    logic [rmau_pkg::FIELD_W-1:0]   residue_a;
    logic [rmau_pkg::FIELD_W-1:0]   operand_b;

    modport source (output valid, func, row_sel, residue_a, operand_b, input ready);
    modport sink   (input valid, func, row_sel, residue_a, operand_b, output ready);
endinterface

[rtl/core/rmau_out_if.sv]
interface rmau_out_if;
    logic                           valid;
    logic                           ready;
    logic [rmau_pkg::FIELD_W-1:0]   result;
    logic [rmau_pkg::STATUS_W-1:0]  status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

[rtl/core/rns_modular_alu_unit.sv]
// add/sub are computed in the check state; multiply runs the bit-serial shift-add loop,
// power runs square-and-multiply over the 16-bit exponent, divide runs euclid steps with
// a restoring division each, after the check and before the final test and final multiply
// one item in flight; the bit-serial shift-add multiplier and restoring divider set the pace
// a new item is taken while a finished result waits in the output register
// reset (synchronous, active low) sets primes to 2, exponent to 1, returns to idle
module rns_modular_alu_unit #(
    parameter int NUM_PRIMES   = rmau_pkg::NUM_PRIMES_D,
    parameter int RESIDUE_BITS = rmau_pkg::RES_BITS_D
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rmau_in_if.sink                           i_in,
    rmau_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rmau_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rmau_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rmau_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int RW = (RESIDUE_BITS < rmau_pkg::FIELD_W) ? RESIDUE_BITS : rmau_pkg::FIELD_W;
    localparam int CW = $clog2(RW + 1);

    function automatic logic [RW-1:0] addm(logic [RW-1:0] x, logic [RW-1:0] y,
                                           logic [RW-1:0] p);
        logic [RW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[RW-1:0];
    endfunction

    // wraps modulo 2^RW, exact since the true result is below p
    function automatic logic [RW-1:0] subm(logic [RW-1:0] x, logic [RW-1:0] y,
                                           logic [RW-1:0] p);
        logic [RW-1:0] d;
        d = (x >= y) ? (x - y) : (x + p - y);
        return d;
    endfunction

    rmau_pkg::t_state   r_state, n_state;
    rmau_pkg::t_mul_dst r_mdst, n_mdst;
    rmau_pkg::t_status  r_status, n_status;

    logic [RW-1:0]                 r_prime [rmau_pkg::ROW_REGS];
    logic [rmau_pkg::EXP_W-1:0]    r_exp;
    logic [rmau_pkg::FUNC_W-1:0]   r_func, n_func;
    logic [rmau_pkg::ROW_W-1:0]    r_row, n_row;
    logic [RW-1:0]                 r_a, n_a, r_b, n_b, r_p, n_p, r_res, n_res;
    logic [RW-1:0]                 r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    logic [RW-1:0]                 r_m, n_m, r_rem, n_rem, r_dvd, n_dvd;
    logic [RW-1:0]                 r_macc, n_macc, r_md, n_md, r_my, n_my;
    logic [RW-1:0]                 r_pacc, n_pacc, r_pbase, n_pbase;
    logic [rmau_pkg::EXP_W-1:0]    r_e, n_e;
    logic [CW-1:0]                 r_cnt, n_cnt;

    logic                          r_out_valid;
    logic [RW-1:0]                 r_out_result;
    rmau_pkg::t_status             r_out_status;

    logic                          w_in_acc, w_out_free, w_cfg_wr;
    logic [RW-1:0]                 w_p;
    logic                          w_badrow, w_range, w_cnt_zero;
    logic [RW:0]                   w_rem_sh, w_rem_sub;
    logic                          w_qbit;
    logic [RW-1:0]                 w_m2;
    logic [2:0]                    w_reg_idx;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_reg_idx  = paddr[5:3];

    assign w_p        = r_prime[r_row];
    assign w_badrow   = (int'(r_row) >= NUM_PRIMES) || (w_p < RW'(2));
    assign w_range    = (r_func > rmau_pkg::FN_POW) || (r_a >= w_p) ||
                        ((r_func != rmau_pkg::FN_POW) && (r_b >= w_p));
    assign w_cnt_zero = (r_cnt == '0);

    // restoring division step and running quotient times t1 mod p
    assign w_rem_sh  = {r_rem, r_dvd[RW-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_r1});
    assign w_rem_sub = w_qbit ? (w_rem_sh - {1'b0, r_r1}) : w_rem_sh;
    assign w_m2      = addm(r_m, r_m, r_p);

    assign i_in.ready   = (r_state == rmau_pkg::S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.result = rmau_pkg::FIELD_W'(r_out_result);
    assign o_out.status = r_out_status;
    assign pready       = 1'b1;

    always_comb begin
        prdata = '0;
        case (w_reg_idx)
            rmau_pkg::REG_PRIME0: prdata = rmau_pkg::APB_DATA_W'(r_prime[0]);
            rmau_pkg::REG_PRIME1: prdata = rmau_pkg::APB_DATA_W'(r_prime[1]);
            rmau_pkg::REG_PRIME2: prdata = rmau_pkg::APB_DATA_W'(r_prime[2]);
            rmau_pkg::REG_PRIME3: prdata = rmau_pkg::APB_DATA_W'(r_prime[3]);
            rmau_pkg::REG_EXP:    prdata = rmau_pkg::APB_DATA_W'(r_exp);
            default:              prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmau_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = rmau_pkg::S_CHECK;
                end
            end
            rmau_pkg::S_CHECK: begin
                if (w_badrow || w_range) begin
                    n_state = rmau_pkg::S_DONE;
                end else begin
                    case (r_func)
                        rmau_pkg::FN_MUL: n_state = rmau_pkg::S_MUL;
                        rmau_pkg::FN_DIV: n_state = rmau_pkg::S_EUC_CHK;
                        rmau_pkg::FN_POW: n_state = rmau_pkg::S_POW;
                        default:          n_state = rmau_pkg::S_DONE;
                    endcase
                end
            end
            rmau_pkg::S_MUL: begin
                if (w_cnt_zero) begin
                    case (r_mdst)
                        rmau_pkg::MD_FINAL: n_state = rmau_pkg::S_DONE;
                        rmau_pkg::MD_ACC:   n_state = rmau_pkg::S_MUL;
                        default:            n_state = rmau_pkg::S_POW;
                    endcase
                end
            end
            rmau_pkg::S_EUC_CHK: begin
                if (r_r1 != '0) begin
                    n_state = rmau_pkg::S_EUC_DIV;
                end else if (r_r0 != RW'(1)) begin
                    n_state = rmau_pkg::S_DONE;
                end else begin
                    n_state = rmau_pkg::S_MUL;
                end
            end
            rmau_pkg::S_EUC_DIV: begin
                if (w_cnt_zero) begin
                    n_state = rmau_pkg::S_EUC_UPD;
                end
            end
            rmau_pkg::S_EUC_UPD: n_state = rmau_pkg::S_EUC_CHK;
            rmau_pkg::S_POW: begin
                if (r_e == '0) begin
                    n_state = rmau_pkg::S_DONE;
                end else begin
                    n_state = rmau_pkg::S_MUL;
                end
            end
            rmau_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = rmau_pkg::S_IDLE;
                end
            end
            default: n_state = rmau_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_func   = r_func;
        n_row    = r_row;
        n_a      = r_a;
        n_b      = r_b;
        n_p      = r_p;
        n_res    = r_res;
        n_status = r_status;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_t0     = r_t0;
        n_t1     = r_t1;
        n_m      = r_m;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_macc   = r_macc;
        n_md     = r_md;
        n_my     = r_my;
        n_mdst   = r_mdst;
        n_pacc   = r_pacc;
        n_pbase  = r_pbase;
        n_e      = r_e;
        n_cnt    = r_cnt;
        case (r_state)
            rmau_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_func = i_in.func;
                    n_row  = i_in.row_sel;
                    n_a    = i_in.residue_a[RW-1:0];
                    n_b    = i_in.operand_b[RW-1:0];
                end
            end
            rmau_pkg::S_CHECK: begin
                n_p      = w_p;
                n_res    = '0;
                n_status = rmau_pkg::ST_OK;
                if (w_badrow) begin
                    n_status = rmau_pkg::ST_BADROW;
                end else if (w_range) begin
                    n_status = rmau_pkg::ST_RANGE;
                end else begin
                    case (r_func)
                        rmau_pkg::FN_ADD: n_res = addm(r_a, r_b, w_p);
                        rmau_pkg::FN_SUB: n_res = subm(r_a, r_b, w_p);
                        rmau_pkg::FN_MUL: begin
                            n_macc = '0;
                            n_md   = r_a;
                            n_my   = r_b;
                            n_cnt  = CW'(RW);
                            n_mdst = rmau_pkg::MD_FINAL;
                        end
                        rmau_pkg::FN_DIV: begin
                            n_r0 = w_p;
                            n_r1 = r_b;
                            n_t0 = '0;
                            n_t1 = RW'(1);
                        end
                        default: begin
                            n_pacc  = RW'(1);
                            n_pbase = r_a;
                            n_e     = r_exp;
                        end
                    endcase
                end
            end
            rmau_pkg::S_MUL: begin
                if (!w_cnt_zero) begin
                    if (r_my[0]) begin
                        n_macc = addm(r_macc, r_md, r_p);
                    end
                    n_md  = addm(r_md, r_md, r_p);
                    n_my  = r_my >> 1;
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    case (r_mdst)
                        rmau_pkg::MD_FINAL: n_res = r_macc;
                        rmau_pkg::MD_ACC: begin
                            // accumulator done, now square the base
                            n_pacc = r_macc;
                            n_macc = '0;
                            n_md   = r_pbase;
                            n_my   = r_pbase;
                            n_cnt  = CW'(RW);
                            n_mdst = rmau_pkg::MD_BASE;
                        end
                        default: begin
                            n_pbase = r_macc;
                            n_e     = r_e >> 1;
                        end
                    endcase
                end
            end
            rmau_pkg::S_EUC_CHK: begin
                if (r_r1 != '0) begin
                    n_rem = '0;
                    n_dvd = r_r0;
                    n_m   = '0;
                    n_cnt = CW'(RW);
                end else if (r_r0 != RW'(1)) begin
                    n_status = rmau_pkg::ST_NOINV;
                end else begin
                    n_macc = '0;
                    n_md   = r_a;
                    n_my   = r_t0;
                    n_cnt  = CW'(RW);
                    n_mdst = rmau_pkg::MD_FINAL;
                end
            end
            rmau_pkg::S_EUC_DIV: begin
                if (!w_cnt_zero) begin
                    n_rem = w_rem_sub[RW-1:0];
                    n_dvd = r_dvd << 1;
                    n_m   = w_qbit ? addm(w_m2, r_t1, r_p) : w_m2;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            rmau_pkg::S_EUC_UPD: begin
                n_r0 = r_r1;
                n_r1 = r_rem;
                n_t0 = r_t1;
                n_t1 = subm(r_t0, r_m, r_p);
            end
            rmau_pkg::S_POW: begin
                if (r_e == '0) begin
                    n_res = r_pacc;
                end else begin
                    n_macc = '0;
                    n_cnt  = CW'(RW);
                    n_md   = r_e[0] ? r_pacc : r_pbase;
                    n_my   = r_pbase;
                    n_mdst = r_e[0] ? rmau_pkg::MD_ACC : rmau_pkg::MD_BASE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmau_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < rmau_pkg::ROW_REGS; i++) begin
                r_prime[i] <= RW'(2);
            end
            r_exp       <= rmau_pkg::EXP_W'(1);
        end else begin
            r_state <= n_state;
            if (r_state == rmau_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                case (w_reg_idx)
                    rmau_pkg::REG_PRIME0: r_prime[0] <= pwdata[RW-1:0];
                    rmau_pkg::REG_PRIME1: r_prime[1] <= pwdata[RW-1:0];
                    rmau_pkg::REG_PRIME2: r_prime[2] <= pwdata[RW-1:0];
                    rmau_pkg::REG_PRIME3: r_prime[3] <= pwdata[RW-1:0];
                    rmau_pkg::REG_EXP:    r_exp <= pwdata[rmau_pkg::EXP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_row    <= n_row;
        r_a      <= n_a;
        r_b      <= n_b;
        r_p      <= n_p;
        r_res    <= n_res;
        r_status <= n_status;
        r_r0     <= n_r0;
        r_r1     <= n_r1;
        r_t0     <= n_t0;
        r_t1     <= n_t1;
        r_m      <= n_m;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_macc   <= n_macc;
        r_md     <= n_md;
        r_my     <= n_my;
        r_mdst   <= n_mdst;
        r_pacc   <= n_pacc;
        r_pbase  <= n_pbase;
        r_e      <= n_e;
        r_cnt    <= n_cnt;
        if (r_state == rmau_pkg::S_DONE && w_out_free) begin
            r_out_result <= (r_status == rmau_pkg::ST_OK) ? r_res : '0;
            r_out_status <= r_status;
        end
    end

`include "assert_macros.svh"

    `RMAU_ASSERT_NXT(a_accept_to_check, i_clk, i_rst_n, w_in_acc, r_state == rmau_pkg::S_CHECK, "accepted item did not enter check")
    `RMAU_ASSERT_NXT(a_done_loads_out, i_clk, i_rst_n, (r_state == rmau_pkg::S_DONE) && !r_out_valid, r_out_valid, "finished item not presented")
    `RMAU_ASSERT_IMP(a_err_zero_result, i_clk, i_rst_n, r_out_valid && (r_out_status != rmau_pkg::ST_OK), r_out_result == '0, "error item carries nonzero result")
    `RMAU_ASSERT_IMP(a_div_rem_bound, i_clk, i_rst_n, r_state == rmau_pkg::S_EUC_DIV, (r_rem < r_r1) && (r_m < r_p), "divider remainder out of bound")
    `RMAU_ASSERT_IMP(a_mul_bound, i_clk, i_rst_n, r_state == rmau_pkg::S_MUL, (r_macc < r_p) && (r_md < r_p), "multiplier operand not reduced")

endmodule
